[design/tss_pkg.sv]
`timescale 1ns / 1ps
package tss_pkg;

  localparam int MAX_DIMS_DEF = 4;
  localparam int DIM_BITS_DEF = 12;
  localparam int NDIM         = 4;

  // shared unit word width, wrap-around arithmetic
  localparam int W  = 64;
  localparam int CW = $clog2(W) + 1;

  localparam int RANK_W  = 3;
  localparam int SDIM_W  = 2;
  localparam int SPLIT_W = 12;

  localparam int                GRAN_W     = 13;
  localparam logic [GRAN_W-1:0] GRAN_RESET = 13'd32;

  localparam int   ADDR_W   = 3;
  localparam int   APB_DW   = 32;
  localparam logic REG_GRAN = 1'b0;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_MUL,
    OP_DIV,
    OP_GCD
  } unit_op_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_RUN,
    U_SHL,
    U_DONE
  } unit_state_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_INNER,
    S_GUARD,
    S_GCD,
    S_QUO,
    S_LCM,
    S_TOTAL,
    S_DEN,
    S_DGUARD,
    S_NUM,
    S_COUNT,
    S_PROD,
    S_SIZE,
    S_LAST,
    S_USED,
    S_REM,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[design/tss_regs.sv]
`timescale 1ns / 1ps
module tss_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tss_pkg::ADDR_W-1:0]   paddr,
  input  logic [tss_pkg::APB_DW-1:0]   pwdata,
  output logic [tss_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output logic [tss_pkg::GRAN_W-1:0]   granularity
);
  import tss_pkg::*;

  logic sel_gran;
  logic wr_en;

  assign pready   = 1'b1;
  assign sel_gran = (paddr[ADDR_W-1] == REG_GRAN);
  assign wr_en    = psel & penable & pwrite & pready & sel_gran;
  assign prdata   = sel_gran ? APB_DW'(granularity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      granularity <= GRAN_RESET;
    end else if (wr_en) begin
      granularity <= pwdata[GRAN_W-1:0];
    end
  end

endmodule

[design/tss_unit.sv]
`timescale 1ns / 1ps
module tss_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  tss_pkg::unit_req_t      req,
  input  logic [tss_pkg::W-1:0]   opa,
  input  logic [tss_pkg::W-1:0]   opb,
  output tss_pkg::unit_stat_t     stat,
  output logic [tss_pkg::W-1:0]   res
);
  import tss_pkg::*;

  unit_state_t   state, state_next;
  unit_op_t      op, op_next;
  logic [W-1:0]  x, x_next;
  logic [W-1:0]  y, y_next;
  logic [W-1:0]  acc, acc_next;
  logic [CW-1:0] cnt, cnt_next;

  // single shared adder / subtractor
  logic [W:0]    add_a, add_b;
  logic          sub;
  logic [W+1:0]  sum;
  logic          geq;
  logic [W:0]    rem_sh;

  assign rem_sh = {acc, x[W-1]};

  always_comb begin
    add_a = {1'b0, x};
    add_b = {1'b0, y};
    sub   = 1'b1;
    unique case (op)
      OP_ADD: sub = 1'b0;
      OP_MUL: begin
        add_a = {1'b0, acc};
        add_b = {1'b0, x};
        sub   = 1'b0;
      end
      OP_DIV: add_a = rem_sh;
      OP_GCD: ;
    endcase
  end

  assign sum = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} + {{(W+1){1'b0}}, sub};
  assign geq = sum[W+1];

  always_comb begin
    state_next = state;
    unique case (state)
      U_IDLE: if (req.start) state_next = U_RUN;
      U_RUN: begin
        unique case (op)
          OP_ADD: state_next = U_DONE;
          OP_MUL: if (y == '0) state_next = U_DONE;
          OP_DIV: if (cnt == CW'(1)) state_next = U_DONE;
          OP_GCD: if (x == '0) state_next = U_SHL;
        endcase
      end
      U_SHL:  if (cnt == '0) state_next = U_DONE;
      U_DONE: state_next = U_IDLE;
    endcase
  end

  always_comb begin
    op_next  = op;
    x_next   = x;
    y_next   = y;
    acc_next = acc;
    cnt_next = cnt;
    unique case (state)
      U_IDLE: begin
        if (req.start) begin
          op_next  = req.op;
          x_next   = opa;
          y_next   = opb;
          acc_next = '0;
          cnt_next = (req.op == OP_DIV) ? CW'(W) : '0;
        end
      end
      U_RUN: begin
        unique case (op)
          OP_ADD: acc_next = sum[W-1:0];
          OP_MUL: begin
            if (y != '0) begin
              if (y[0]) acc_next = sum[W-1:0];
              x_next = {x[W-2:0], 1'b0};
              y_next = {1'b0, y[W-1:1]};
            end
          end
          OP_DIV: begin
            // restoring division, one quotient bit per cycle
            acc_next = geq ? sum[W-1:0] : rem_sh[W-1:0];
            x_next   = {x[W-2:0], geq};
            cnt_next = cnt - CW'(1);
          end
          OP_GCD: begin
            // binary gcd, cnt holds the common power of two
            if (x != '0) begin
              priority if (!x[0] && !y[0]) begin
                x_next   = {1'b0, x[W-1:1]};
                y_next   = {1'b0, y[W-1:1]};
                cnt_next = cnt + CW'(1);
              end else if (!x[0]) begin
                x_next = {1'b0, x[W-1:1]};
              end else if (!y[0]) begin
                y_next = {1'b0, y[W-1:1]};
              end else if (geq) begin
                x_next = sum[W-1:0];
              end else begin
                x_next = y;
                y_next = x;
              end
            end
          end
        endcase
      end
      U_SHL: begin
        if (cnt != '0) begin
          y_next   = {y[W-2:0], 1'b0};
          cnt_next = cnt - CW'(1);
        end
      end
      U_DONE: ;
    endcase
  end

  always_comb begin
    unique case (op)
      OP_ADD, OP_MUL: res = acc;
      OP_DIV:         res = x;
      OP_GCD:         res = y;
    endcase
  end

  assign stat.busy = (state != U_IDLE);
  assign stat.done = (state == U_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    op  <= op_next;
    x   <= x_next;
    y   <= y_next;
    acc <= acc_next;
    cnt <= cnt_next;
  end

endmodule

[design/tss_seq.sv]
`timescale 1ns / 1ps
module tss_seq #(
  parameter int MAX_DIMS = tss_pkg::MAX_DIMS_DEF,
  parameter int DIM_BITS = tss_pkg::DIM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [DIM_BITS-1:0]           dim_zero,
  input  logic [DIM_BITS-1:0]           dim_one,
  input  logic [DIM_BITS-1:0]           dim_two,
  input  logic [DIM_BITS-1:0]           dim_three,
  input  logic [tss_pkg::RANK_W-1:0]    rank,
  input  logic [tss_pkg::SDIM_W-1:0]    split_dim,
  input  logic [tss_pkg::SPLIT_W-1:0]   num_splits,
  input  logic [tss_pkg::SPLIT_W-1:0]   split_index,
  input  logic [tss_pkg::GRAN_W-1:0]    granularity,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [DIM_BITS-1:0]           split_size,
  output logic                          error,
  output tss_pkg::unit_req_t            ureq,
  output logic [tss_pkg::W-1:0]         uopa,
  output logic [tss_pkg::W-1:0]         uopb,
  input  tss_pkg::unit_stat_t           ustat,
  input  logic [tss_pkg::W-1:0]         ures
);
  import tss_pkg::*;

  localparam logic [RANK_W:0] MAXD  = (RANK_W+1)'(MAX_DIMS);
  localparam logic [RANK_W:0] NDIMR = (RANK_W+1)'(NDIM);

  seq_state_t state, state_next;

  logic [DIM_BITS-1:0] dims [NDIM];
  logic [DIM_BITS-1:0] dims_next [NDIM];
  logic [RANK_W-1:0]   rnk, rnk_next;
  logic [SDIM_W-1:0]   sdim, sdim_next;
  logic [SPLIT_W-1:0]  nspl, nspl_next;
  logic [SPLIT_W-1:0]  sidx, sidx_next;
  logic [RANK_W-1:0]   idx, idx_next;
  logic [W-1:0]        inner, inner_next;
  logic [W-1:0]        lcm, lcm_next;
  logic [W-1:0]        total, total_next;
  logic [W-1:0]        den, den_next;
  logic [W-1:0]        acc, acc_next;
  logic [DIM_BITS-1:0] rsize, rsize_next;
  logic                rerr, rerr_next;
  logic                issued, issued_next;
  logic                res_valid_next;
  logic [DIM_BITS-1:0] split_size_next;
  logic                error_next;

  logic [DIM_BITS-1:0] orig;
  logic [W-1:0]        gw;
  logic [SPLIT_W-1:0]  nm1;
  logic                chk_fail, too_small, one_split;
  logic                gran_fail, den_fail, sat, last_fail, not_last;
  logic                op_need, op_done, out_free;
  unit_op_t            op_sel;

  assign orig      = dims[sdim];
  assign gw        = W'(granularity);
  assign nm1       = nspl - SPLIT_W'(1);
  assign chk_fail  = (rnk == '0) || ({1'b0, rnk} > MAXD) || ({1'b0, rnk} > NDIMR)
                     || (RANK_W'(sdim) >= rnk) || (nspl == '0) || (sidx >= nspl);
  assign too_small = W'(orig) <= W'(nspl);
  assign one_split = (nspl == SPLIT_W'(1));
  assign gran_fail = (granularity == '0) || (inner == '0);
  assign den_fail  = (lcm == '0) || (den[W-2:0] == '0);
  assign sat       = |acc[W-1:DIM_BITS];
  assign not_last  = sidx < nm1;
  assign last_fail = den > W'(orig);
  assign out_free  = !res_valid || res_ready;

  assign item_ready = (state == S_IDLE);

  // operation and operands for the shared unit
  always_comb begin
    op_need = 1'b1;
    op_sel  = OP_MUL;
    uopa    = inner;
    uopb    = '0;
    unique case (state)
      S_INNER: begin
        op_need = idx < rnk;
        uopb    = W'(dims[idx[SDIM_W-1:0]]);
      end
      S_GCD: begin
        op_sel = OP_GCD;
        uopb   = gw;
      end
      S_QUO: begin
        op_sel = OP_DIV;
        uopb   = acc;
      end
      S_LCM: begin
        uopa = acc;
        uopb = gw;
      end
      S_TOTAL: uopb = W'(orig);
      S_DEN: begin
        uopa = lcm;
        uopb = W'(nspl);
      end
      S_NUM: begin
        op_sel = OP_ADD;
        uopa   = {total[W-2:0], 1'b0};
        uopb   = den;
      end
      S_COUNT: begin
        op_sel = OP_DIV;
        uopa   = acc;
        uopb   = {den[W-2:0], 1'b0};
      end
      S_PROD: begin
        uopa = lcm;
        uopb = acc;
      end
      S_SIZE: begin
        op_sel = OP_DIV;
        uopa   = acc;
        uopb   = inner;
      end
      S_USED: begin
        uopa = acc;
        uopb = W'(nm1);
      end
      default: op_need = 1'b0;
    endcase
  end

  assign ureq.start = op_need && !issued && !ustat.busy;
  assign ureq.op    = op_sel;
  assign op_done    = op_need && issued && ustat.done;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (item_valid) state_next = S_CHECK;
      S_CHECK:  state_next = (chk_fail || too_small || one_split) ? S_OUT : S_INNER;
      S_INNER:  if (!op_need) state_next = S_GUARD;
      S_GUARD:  state_next = gran_fail ? S_OUT : S_GCD;
      S_GCD:    if (op_done) state_next = S_QUO;
      S_QUO:    if (op_done) state_next = S_LCM;
      S_LCM:    if (op_done) state_next = S_TOTAL;
      S_TOTAL:  if (op_done) state_next = S_DEN;
      S_DEN:    if (op_done) state_next = S_DGUARD;
      S_DGUARD: state_next = den_fail ? S_OUT : S_NUM;
      S_NUM:    if (op_done) state_next = S_COUNT;
      S_COUNT:  if (op_done) state_next = S_PROD;
      S_PROD:   if (op_done) state_next = S_SIZE;
      S_SIZE:   if (op_done) state_next = S_LAST;
      S_LAST:   state_next = not_last ? S_OUT : S_USED;
      S_USED:   if (op_done) state_next = S_REM;
      S_REM:    state_next = S_OUT;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    dims_next       = dims;
    rnk_next        = rnk;
    sdim_next       = sdim;
    nspl_next       = nspl;
    sidx_next       = sidx;
    idx_next        = idx;
    inner_next      = inner;
    lcm_next        = lcm;
    total_next      = total;
    den_next        = den;
    acc_next        = acc;
    rsize_next      = rsize;
    rerr_next       = rerr;
    split_size_next = split_size;
    error_next      = error;
    issued_next     = ureq.start ? 1'b1 : (op_done ? 1'b0 : issued);
    res_valid_next  = (res_valid && res_ready) ? 1'b0 : res_valid;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          dims_next[0] = dim_zero;
          dims_next[1] = dim_one;
          dims_next[2] = dim_two;
          dims_next[3] = dim_three;
          rnk_next     = rank;
          sdim_next    = split_dim;
          nspl_next    = num_splits;
          sidx_next    = split_index;
        end
      end
      S_CHECK: begin
        if (chk_fail || too_small) begin
          rsize_next = '0;
          rerr_next  = 1'b1;
        end else if (one_split) begin
          rsize_next = orig;
          rerr_next  = 1'b0;
        end else begin
          inner_next = W'(1);
          idx_next   = RANK_W'(sdim) + RANK_W'(1);
        end
      end
      S_INNER: begin
        if (op_done) begin
          inner_next = ures;
          idx_next   = idx + RANK_W'(1);
        end
      end
      S_GUARD: begin
        if (gran_fail) begin
          rsize_next = '0;
          rerr_next  = 1'b1;
        end
      end
      S_GCD, S_QUO, S_NUM, S_COUNT, S_PROD, S_SIZE: begin
        if (op_done) acc_next = ures;
      end
      S_LCM:   if (op_done) lcm_next = ures;
      S_TOTAL: if (op_done) total_next = ures;
      S_DEN, S_USED: begin
        if (op_done) den_next = ures;
      end
      S_DGUARD: begin
        if (den_fail) begin
          rsize_next = '0;
          rerr_next  = 1'b1;
        end
      end
      S_LAST: begin
        if (not_last) begin
          rsize_next = sat ? '1 : acc[DIM_BITS-1:0];
          rerr_next  = sat;
        end
      end
      S_REM: begin
        if (last_fail) begin
          rsize_next = '0;
          rerr_next  = 1'b1;
        end else begin
          rsize_next = orig - den[DIM_BITS-1:0];
          rerr_next  = 1'b0;
        end
      end
      S_OUT: begin
        if (out_free) begin
          split_size_next = rsize;
          error_next      = rerr;
          res_valid_next  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      issued    <= issued_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    dims       <= dims_next;
    rnk        <= rnk_next;
    sdim       <= sdim_next;
    nspl       <= nspl_next;
    sidx       <= sidx_next;
    idx        <= idx_next;
    inner      <= inner_next;
    lcm        <= lcm_next;
    total      <= total_next;
    den        <= den_next;
    acc        <= acc_next;
    rsize      <= rsize_next;
    rerr       <= rerr_next;
    split_size <= split_size_next;
    error      <= error_next;
  end

endmodule

[design/tensor_split_size.sv]
`timescale 1ns / 1ps
// Channel   Direction  Contents
// s_axis    in         one request item: shape, rank, split dim, split count, split index
// m_axis    out        one result item per request: split size, error flag in tuser
// apb       in/out     granularity register at byte address 0
//
// An item is worked on one step at a time by a single 65-bit adder (shift-add multiply,
// restoring divide with 64 steps, binary gcd): three divisions and up to eight multiplies
// per item; errors caught early in the argument check skip the arithmetic.
// s_axis_tready is high only while the sequencer is idle; the result register lets a
// new item in while a result waits. rst is synchronous; no memory needs clearing.
module tensor_split_size #(
  parameter  int MAX_DIMS   = tss_pkg::MAX_DIMS_DEF,
  parameter  int DIM_BITS   = tss_pkg::DIM_BITS_DEF,
  localparam int IN_BITS    = 4 * DIM_BITS + tss_pkg::RANK_W + tss_pkg::SDIM_W
                              + 2 * tss_pkg::SPLIT_W,
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((DIM_BITS + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // dim_zero, dim_one, dim_two, dim_three, rank, split_dim, num_splits, split_index
  input  logic [IN_TDATA_W-1:0]        s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // split_size
  output logic [OUT_TDATA_W-1:0]       m_axis_tdata,
  // error
  output logic                         m_axis_tuser,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tss_pkg::ADDR_W-1:0]   paddr,
  input  logic [tss_pkg::APB_DW-1:0]   pwdata,
  output logic [tss_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import tss_pkg::*;

  localparam int O_D1 = DIM_BITS;
  localparam int O_D2 = 2 * DIM_BITS;
  localparam int O_D3 = 3 * DIM_BITS;
  localparam int O_RK = 4 * DIM_BITS;
  localparam int O_SD = O_RK + RANK_W;
  localparam int O_NS = O_SD + SDIM_W;
  localparam int O_SI = O_NS + SPLIT_W;

  logic [GRAN_W-1:0]   granularity;
  logic [DIM_BITS-1:0] split_size;
  unit_req_t           ureq;
  unit_stat_t          ustat;
  logic [W-1:0]        uopa, uopb, ures;

  tss_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .granularity (granularity)
  );

  tss_seq #(
    .MAX_DIMS (MAX_DIMS),
    .DIM_BITS (DIM_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (s_axis_tvalid),
    .item_ready  (s_axis_tready),
    .dim_zero    (s_axis_tdata[0 +: DIM_BITS]),
    .dim_one     (s_axis_tdata[O_D1 +: DIM_BITS]),
    .dim_two     (s_axis_tdata[O_D2 +: DIM_BITS]),
    .dim_three   (s_axis_tdata[O_D3 +: DIM_BITS]),
    .rank        (s_axis_tdata[O_RK +: RANK_W]),
    .split_dim   (s_axis_tdata[O_SD +: SDIM_W]),
    .num_splits  (s_axis_tdata[O_NS +: SPLIT_W]),
    .split_index (s_axis_tdata[O_SI +: SPLIT_W]),
    .granularity (granularity),
    .res_valid   (m_axis_tvalid),
    .res_ready   (m_axis_tready),
    .split_size  (split_size),
    .error       (m_axis_tuser),
    .ureq        (ureq),
    .uopa        (uopa),
    .uopb        (uopb),
    .ustat       (ustat),
    .ures        (ures)
  );

  tss_unit u_unit (
    .clk  (clk),
    .rst  (rst),
    .req  (ureq),
    .opa  (uopa),
    .opb  (uopb),
    .stat (ustat),
    .res  (ures)
  );

  assign m_axis_tdata = OUT_TDATA_W'(split_size);

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import tss_pkg::*;

  localparam int DIM_W       = DIM_BITS_DEF;
  localparam int REQ_W       = 4 * DIM_W + RANK_W + SDIM_W + 2 * SPLIT_W;
  localparam int IN_TDATA_W  = ((REQ_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DIM_W + 7) / 8) * 8;
  localparam logic [63:0] DIM_MAX = (64'd1 << DIM_W) - 64'd1;
  localparam logic [ADDR_W-1:0] GRAN_ADDR = ADDR_W'(4 * int'(REG_GRAN));

  typedef struct packed {
    logic [SPLIT_W-1:0] split_index;
    logic [SPLIT_W-1:0] num_splits;
    logic [SDIM_W-1:0]  split_dim;
    logic [RANK_W-1:0]  rank;
    logic [DIM_W-1:0]   dim_three;
    logic [DIM_W-1:0]   dim_two;
    logic [DIM_W-1:0]   dim_one;
    logic [DIM_W-1:0]   dim_zero;
  } split_req_t;

  typedef struct packed {
    logic [DIM_W-1:0] split_size;
    logic             error;
  } split_result_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // dim_zero, dim_one, dim_two, dim_three, rank, split_dim, num_splits, split_index
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // split_size
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // error
  logic                   m_axis_tuser;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_W-1:0]      paddr;
  logic [APB_DW-1:0]      pwdata;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  split_result_t     pending_sizes[$];
  logic [GRAN_W-1:0] gran_model;
  int                mismatches;
  int                snd_idle_pct;
  int                rcv_idle_pct;
  int                hold_len;
  int                hold_trigger;

  tensor_split_size DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic split_result_t predict_split(split_req_t r, logic [GRAN_W-1:0] gran);
    logic [63:0]   dims [NDIM];
    logic [63:0]   rank, sd, n, k, orig, inner, a, b, t, lcm, total, den, count, size, used;
    split_result_t res;
    int            i;
    dims[0] = r.dim_zero;
    dims[1] = r.dim_one;
    dims[2] = r.dim_two;
    dims[3] = r.dim_three;
    rank = r.rank;
    sd = r.split_dim;
    n = r.num_splits;
    k = r.split_index;
    res.split_size = '0;
    res.error = 1'b1;
    if (rank == 0 || rank > MAX_DIMS_DEF || rank > NDIM || sd >= rank || n == 0 || k >= n)
      return res;
    orig = dims[sd];
    if (orig <= n) return res;
    if (n == 1) begin
      res.split_size = orig[DIM_W-1:0];
      res.error = 1'b0;
      return res;
    end
    inner = 64'd1;
    for (i = int'(sd) + 1; i < int'(rank); i++) inner = inner * dims[i];
    if (gran == 0 || inner == 0) return res;
    a = inner;
    b = 64'(gran);
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    lcm = (inner / a) * 64'(gran);
    total = inner * orig;
    den = n * lcm;
    if (lcm == 0 || den == 0 || (den << 1) == 0) return res;
    count = ((total << 1) + den) / (den << 1);
    size = (count * lcm) / inner;
    if (k < n - 1) begin
      if (size > DIM_MAX) begin
        res.split_size = '1;
      end else begin
        res.split_size = size[DIM_W-1:0];
        res.error = 1'b0;
      end
      return res;
    end
    used = (n - 1) * size;
    if (used > orig) return res;
    size = orig - used;
    res.split_size = size[DIM_W-1:0];
    res.error = 1'b0;
    return res;
  endfunction

  task automatic log_mismatch(string what, logic [31:0] exp_val, logic [31:0] act_val);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d at %0t: %s expected %0d got %0d", mismatches, $time, what,
               exp_val, act_val);
  endtask

  // result checker
  always @(posedge clk) begin
    split_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_sizes.size() == 0) begin
        log_mismatch("unexpected item, split_size", 0, 32'(m_axis_tdata));
      end else begin
        want = pending_sizes.pop_front();
        if (m_axis_tdata !== OUT_TDATA_W'(want.split_size))
          log_mismatch("split_size", 32'(want.split_size), 32'(m_axis_tdata));
        if (m_axis_tuser !== want.error)
          log_mismatch("error", 32'(want.error), 32'(m_axis_tuser));
      end
    end
  end

  // result side ready, with random stalls and long hold-offs on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  task automatic send_request(split_req_t r);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata <= IN_TDATA_W'(r);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_sizes.push_back(predict_split(r, gran_model));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_sizes.size() != 0) @(negedge clk);
  endtask

  task automatic write_granularity(logic [GRAN_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= GRAN_ADDR;
    pwdata <= APB_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    gran_model = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DW'(value))
      log_mismatch("granularity readback", 32'(value), 32'(prdata));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic split_req_t make_request(int d0, int d1, int d2, int d3, int rank,
                                              int sd, int n, int k);
    split_req_t r;
    r.dim_zero = DIM_W'(d0);
    r.dim_one = DIM_W'(d1);
    r.dim_two = DIM_W'(d2);
    r.dim_three = DIM_W'(d3);
    r.rank = RANK_W'(rank);
    r.split_dim = SDIM_W'(sd);
    r.num_splits = SPLIT_W'(n);
    r.split_index = SPLIT_W'(k);
    return r;
  endfunction

  function automatic int random_dim();
    int pick;
    pick = $urandom_range(99);
    if (pick < 65) return $urandom_range(1, 64);
    if (pick < 88) return $urandom_range(1, 4095);
    if (pick < 94) return 4095;
    return 0;
  endfunction

  function automatic split_req_t random_request();
    int dims [NDIM];
    int rank, sd, orig, n, k, pick, i;
    if ($urandom_range(99) < 12)
      return make_request($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 7),
                          $urandom_range(0, 3), $urandom_range(0, 4095),
                          $urandom_range(0, 4095));
    for (i = 0; i < NDIM; i++) dims[i] = random_dim();
    rank = $urandom_range(1, 4);
    sd = $urandom_range(0, rank - 1);
    orig = ($urandom_range(99) < 50) ? $urandom_range(2, 200) : $urandom_range(2, 4095);
    dims[sd] = orig;
    pick = $urandom_range(99);
    if (pick < 10) n = 1;
    else if (pick < 55) n = $urandom_range(2, (orig - 1 < 16) ? orig - 1 : 16);
    else if (pick < 95) n = $urandom_range(2, orig - 1);
    else n = orig;
    pick = $urandom_range(99);
    if (pick < 50) k = n - 1;
    else if (pick < 96) k = $urandom_range(0, n - 1);
    else k = n;
    return make_request(dims[0], dims[1], dims[2], dims[3], rank, sd, n, k);
  endfunction

  function automatic logic [GRAN_W-1:0] random_granularity();
    case ($urandom_range(0, 4))
      0: return GRAN_W'(1 << $urandom_range(0, 12));
      1: return GRAN_W'($urandom_range(1, 16));
      2: return GRAN_W'($urandom_range(1, 300));
      default: return GRAN_W'($urandom_range(1, 4096));
    endcase
  endfunction

  // runs at the reset granularity
  task automatic test_argument_checks();
    send_request(make_request(100, 1, 1, 1, 0, 0, 2, 0));
    send_request(make_request(100, 1, 1, 1, 5, 0, 2, 0));
    send_request(make_request(100, 1, 1, 1, 7, 0, 2, 0));
    send_request(make_request(100, 8, 1, 1, 2, 3, 2, 0));
    send_request(make_request(100, 1, 1, 1, 1, 0, 0, 0));
    send_request(make_request(100, 1, 1, 1, 1, 0, 5, 5));
    send_request(make_request(5, 1, 1, 1, 1, 0, 5, 4));
    send_request(make_request(4095, 1, 1, 1, 1, 0, 4095, 4094));
    send_request(make_request(100, 3, 0, 7, 3, 0, 3, 0));
    send_request(make_request(0, 0, 0, 0, 4, 0, 4095, 4095));
  endtask

  task automatic test_shape_extremes();
    send_request(make_request(4095, 4095, 4095, 4095, 4, 0, 1, 0));
    send_request(make_request(4095, 4095, 4095, 4095, 4, 0, 4094, 0));
    send_request(make_request(4095, 4095, 4095, 4095, 4, 0, 4094, 4093));
    send_request(make_request(1, 2, 3, 4095, 4, 3, 2, 0));
    send_request(make_request(1, 2, 3, 4095, 4, 3, 2, 1));
    send_request(make_request(7, 300, 17, 9, 4, 1, 7, 6));
    send_request(make_request(2, 1, 1, 1, 1, 0, 1, 0));
  endtask

  task automatic test_granularity_corners();
    wait_drained();
    write_granularity(GRAN_W'(4));
    // last split would go negative
    send_request(make_request(11, 0, 0, 0, 1, 0, 4, 3));
    send_request(make_request(11, 0, 0, 0, 1, 0, 4, 0));
    wait_drained();
    write_granularity(GRAN_W'(1));
    send_request(make_request(4095, 0, 0, 0, 1, 0, 2, 0));
    send_request(make_request(4095, 0, 0, 0, 1, 0, 2, 1));
    wait_drained();
    write_granularity(GRAN_W'(4096));
    // granularity above the dimension range, so the non-last sizes round down to zero
    send_request(make_request(4095, 0, 0, 0, 1, 0, 2, 0));
    send_request(make_request(4095, 0, 0, 0, 1, 0, 2, 1));
    send_request(make_request(64, 4095, 4095, 1, 3, 0, 3, 1));
  endtask

  task automatic test_random_traffic(int count);
    int phase;
    for (phase = 0; phase < 3; phase++) begin
      wait_drained();
      write_granularity(random_granularity());
      repeat (count / 3) send_request(random_request());
    end
  endtask

  task automatic test_receiver_holdoff();
    wait_drained();
    hold_len = 3000;
    hold_trigger++;
    repeat (12) send_request(random_request());
    wait_drained();
  endtask

  task automatic test_sender_pause();
    repeat (6) send_request(random_request());
    wait_drained();
    repeat (6) send_request(random_request());
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gran_model = GRAN_RESET;
    mismatches = 0;
    hold_len = 0;
    hold_trigger = 0;
    snd_idle_pct = 35;
    rcv_idle_pct = 74;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_argument_checks();
    test_shape_extremes();
    test_granularity_corners();
    test_random_traffic(450);
    snd_idle_pct = 74;
    rcv_idle_pct = 35;
    test_random_traffic(450);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_traffic(450);
    test_receiver_holdoff();
    test_sender_pause();

    wait_drained();
    repeat (600) @(negedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
